[rtl/i2c_register_burst_master_top_macros.svh]
// Assertion macros for the I2C register burst master.
// Expects clk and rst_n in the scope of each use; depends on nothing else.
`ifndef I2C_REGISTER_BURST_MASTER_TOP_MACROS_SVH
`define I2C_REGISTER_BURST_MASTER_TOP_MACROS_SVH

// same-cycle implication
`define I2CRBM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define I2CRBM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/i2crbm_pkg.sv]
// Shared types and constants of the I2C register burst master.
// Request, result and configuration structs, action and configuration codes and reset values; no dependencies.
`default_nettype none

package i2crbm_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_SETUP_TICKS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_TICKS     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TICKS     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_POLL_LIMIT = 2'd3;

    localparam logic [9:0] SETUP_TICKS_RST    = 10'd2;
    localparam logic [9:0] HIGH_TICKS_RST     = 10'd5;
    localparam logic [9:0] HOLD_TICKS_RST     = 10'd3;
    localparam logic [7:0] ACK_POLL_LIMIT_RST = 8'd50;

    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_PUSH  = 2'd1;
    localparam logic [1:0] ACT_WRITE = 2'd2;
    localparam logic [1:0] ACT_READ  = 2'd3;

    typedef struct packed {
        logic [1:0] action;
        logic [6:0] device_addr;
        logic [7:0] reg_addr;
        logic [4:0] byte_count;
        logic [7:0] write_byte;
        logic       sda_sample;
    } in_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_enable;
        logic [7:0] read_byte;
        logic       read_valid;
        logic       read_last;
        logic       busy_res;
        logic       done_res;
        logic       ack_error;
    } out_t;

    typedef struct packed {
        logic [9:0] setup_ticks;
        logic [9:0] high_ticks;
        logic [9:0] hold_ticks;
        logic [7:0] ack_poll_limit;
    } cfg_t;

endpackage

`default_nettype wire

[rtl/i2crbm_core.sv]
// Bus sequencer of the I2C register burst master: one tick per step.
// Holds the phase machine and the write byte buffer; uses i2crbm_pkg.
`default_nettype none

module i2crbm_core #(
    parameter int BURST_DEPTH = 16
) (
    input  wire                logic clk,
    input  wire                logic rst_n,
    input  wire                logic step,
    input  i2crbm_pkg::in_t    item,
    input  i2crbm_pkg::cfg_t   cfg,
    output i2crbm_pkg::out_t   res
);

    localparam int CNT_W = $clog2(BURST_DEPTH + 1);
    localparam int IDX_W = (BURST_DEPTH > 1) ? $clog2(BURST_DEPTH) : 1;
    localparam int LEN_W = (CNT_W > 5) ? CNT_W : 5;

    typedef enum logic [4:0] {
        P_IDLE, P_START_A, P_START_B, P_TX_SETUP, P_TX_HIGH, P_TX_HOLD,
        P_ACK_SETTLE, P_ACK_POLL, P_ACK_GAP, P_ACK_HIGH,
        P_RX_LOW, P_RX_HIGH, P_MA_LOW, P_MA_HIGH,
        P_STOP_A, P_STOP_B, P_STOP_C
    } phase_t;

    typedef enum logic [1:0] {
        ST_DEV, ST_REG, ST_RADDR, ST_DATA
    } stage_t;

    phase_t           phase_reg, phase_next;
    stage_t           stage_reg, stage_next;
    logic [9:0]       tick_reg, tick_next;
    logic [3:0]       bit_reg, bit_next;
    logic [CNT_W-1:0] byte_reg, byte_next;
    logic [7:0]       shift_reg, shift_next;
    logic [7:0]       poll_reg, poll_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [6:0]       dev_reg, dev_next;
    logic [7:0]       regaddr_reg, regaddr_next;
    logic [CNT_W-1:0] len_reg, len_next;
    logic             read_mode_reg, read_mode_next;
    logic             abort_reg, abort_next;

    logic [7:0]       wbuf_mem [BURST_DEPTH];
    logic [7:0]       mem_rd_reg;
    logic [IDX_W-1:0] rd_addr;
    logic [CNT_W:0]   rd_sum;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;

    logic [9:0]       dur;
    logic             timed;
    logic             tx_bit;

    always_comb
    begin
        rd_sum = (CNT_W+1)'(byte_reg) + (CNT_W+1)'(1);
        if (stage_reg == ST_DATA && rd_sum < (CNT_W+1)'(BURST_DEPTH))
        begin
            rd_addr = IDX_W'(rd_sum);
        end
        else
        begin
            rd_addr = '0;
        end
    end

    always_comb
    begin
        phase_next     = phase_reg;
        stage_next     = stage_reg;
        tick_next      = tick_reg;
        bit_next       = bit_reg;
        byte_next      = byte_reg;
        shift_next     = shift_reg;
        poll_next      = poll_reg;
        fill_next      = fill_reg;
        dev_next       = dev_reg;
        regaddr_next   = regaddr_reg;
        len_next       = len_reg;
        read_mode_next = read_mode_reg;
        abort_next     = abort_reg;
        mem_we         = 1'b0;
        mem_waddr      = IDX_W'(fill_reg);
        timed          = 1'b1;
        dur            = 10'd1;
        res            = '0;
        res.scl_level  = 1'b1;
        res.sda_level  = 1'b1;
        res.sda_enable = 1'b1;

        if (phase_reg == P_IDLE)
        begin
            if (item.action == i2crbm_pkg::ACT_PUSH)
            begin
                if (fill_reg < CNT_W'(BURST_DEPTH))
                begin
                    mem_we    = 1'b1;
                    fill_next = fill_reg + CNT_W'(1);
                end
            end
            else if (item.action == i2crbm_pkg::ACT_WRITE ||
                     item.action == i2crbm_pkg::ACT_READ)
            begin
                dev_next     = item.device_addr;
                regaddr_next = item.reg_addr;
                if (LEN_W'(item.byte_count) > LEN_W'(BURST_DEPTH))
                begin
                    len_next = CNT_W'(BURST_DEPTH);
                end
                else
                begin
                    len_next = CNT_W'(item.byte_count);
                end
                read_mode_next = (item.action == i2crbm_pkg::ACT_READ);
                if (item.action == i2crbm_pkg::ACT_WRITE)
                begin
                    fill_next = '0;
                end
                byte_next  = '0;
                poll_next  = '0;
                abort_next = 1'b0;
                stage_next = ST_DEV;
                phase_next = P_START_A;
                tick_next  = '0;
            end
        end

        res.busy_res = (phase_next != P_IDLE);
        tx_bit       = shift_next[7];

        case (phase_next)
            P_START_A:
            begin
                res.scl_level = 1'b1;
                res.sda_level = 1'b1;
            end
            P_START_B:
            begin
                res.scl_level = 1'b1;
                res.sda_level = 1'b0;
            end
            P_TX_SETUP, P_TX_HOLD:
            begin
                res.scl_level = 1'b0;
                res.sda_level = tx_bit;
            end
            P_TX_HIGH:
            begin
                res.scl_level = 1'b1;
                res.sda_level = tx_bit;
            end
            P_ACK_SETTLE, P_ACK_POLL, P_ACK_GAP, P_RX_LOW:
            begin
                res.scl_level  = 1'b0;
                res.sda_enable = 1'b0;
            end
            P_ACK_HIGH, P_RX_HIGH:
            begin
                res.scl_level  = 1'b1;
                res.sda_enable = 1'b0;
            end
            P_MA_LOW, P_MA_HIGH:
            begin
                res.scl_level = (phase_next == P_MA_HIGH);
                res.sda_level = ((CNT_W+1)'(byte_next) + (CNT_W+1)'(1))
                                >= (CNT_W+1)'(len_next);
            end
            P_STOP_A:
            begin
                res.scl_level = 1'b0;
                res.sda_level = 1'b0;
            end
            P_STOP_B:
            begin
                res.scl_level = 1'b1;
                res.sda_level = 1'b0;
            end
            default:
            begin
                res.scl_level = 1'b1;
                res.sda_level = 1'b1;
            end
        endcase

        if (phase_next == P_IDLE)
        begin
            timed = 1'b0;
        end
        else if (phase_next == P_ACK_POLL)
        begin
            timed = 1'b0;
            if (!item.sda_sample)
            begin
                phase_next = P_ACK_HIGH;
                tick_next  = '0;
            end
            else if (poll_next >= cfg.ack_poll_limit)
            begin
                abort_next = 1'b1;
                phase_next = P_STOP_A;
                tick_next  = '0;
            end
            else
            begin
                poll_next  = poll_next + 8'd1;
                phase_next = P_ACK_GAP;
                tick_next  = '0;
            end
        end
        else if (phase_next == P_RX_HIGH && tick_next == 10'd0)
        begin
            shift_next = {shift_next[6:0], item.sda_sample};
            if (bit_next == 4'd7)
            begin
                res.read_valid = 1'b1;
                res.read_byte  = shift_next;
                res.read_last  = ((CNT_W+1)'(byte_next) + (CNT_W+1)'(1))
                                 >= (CNT_W+1)'(len_next);
            end
        end

        case (phase_next)
            P_TX_SETUP: dur = (cfg.setup_ticks == 10'd0) ? 10'd1 : cfg.setup_ticks;
            P_TX_HOLD:  dur = (cfg.hold_ticks == 10'd0) ? 10'd1 : cfg.hold_ticks;
            default:    dur = (cfg.high_ticks == 10'd0) ? 10'd1 : cfg.high_ticks;
        endcase

        if (timed)
        begin
            if ((11'(tick_next) + 11'd1) < 11'(dur))
            begin
                tick_next = tick_next + 10'd1;
            end
            else
            begin
                tick_next = '0;
                case (phase_next)
                    P_START_A: phase_next = P_START_B;
                    P_START_B:
                    begin
                        shift_next = {dev_next, (stage_next == ST_RADDR)};
                        bit_next   = '0;
                        phase_next = P_TX_SETUP;
                    end
                    P_TX_SETUP: phase_next = P_TX_HIGH;
                    P_TX_HIGH:  phase_next = P_TX_HOLD;
                    P_TX_HOLD:
                    begin
                        shift_next = {shift_next[6:0], 1'b0};
                        bit_next   = bit_next + 4'd1;
                        phase_next = (bit_next >= 4'd8) ? P_ACK_SETTLE : P_TX_SETUP;
                    end
                    P_ACK_SETTLE:
                    begin
                        poll_next  = '0;
                        phase_next = P_ACK_POLL;
                    end
                    P_ACK_GAP: phase_next = P_ACK_POLL;
                    P_ACK_HIGH:
                    begin
                        case (stage_next)
                            ST_DEV:
                            begin
                                stage_next = ST_REG;
                                shift_next = regaddr_next;
                                bit_next   = '0;
                                phase_next = P_TX_SETUP;
                            end
                            ST_REG:
                            begin
                                if (read_mode_next)
                                begin
                                    stage_next = ST_RADDR;
                                    phase_next = P_START_A;
                                end
                                else if (len_next != '0)
                                begin
                                    stage_next = ST_DATA;
                                    byte_next  = '0;
                                    shift_next = mem_rd_reg;
                                    bit_next   = '0;
                                    phase_next = P_TX_SETUP;
                                end
                                else
                                begin
                                    phase_next = P_STOP_A;
                                end
                            end
                            ST_RADDR:
                            begin
                                byte_next = '0;
                                if (len_next != '0)
                                begin
                                    shift_next = '0;
                                    bit_next   = '0;
                                    phase_next = P_RX_LOW;
                                end
                                else
                                begin
                                    phase_next = P_STOP_A;
                                end
                            end
                            default:
                            begin
                                byte_next = byte_next + CNT_W'(1);
                                if (byte_next < len_next &&
                                    byte_next < CNT_W'(BURST_DEPTH))
                                begin
                                    shift_next = mem_rd_reg;
                                    bit_next   = '0;
                                    phase_next = P_TX_SETUP;
                                end
                                else
                                begin
                                    phase_next = P_STOP_A;
                                end
                            end
                        endcase
                    end
                    P_RX_LOW: phase_next = P_RX_HIGH;
                    P_RX_HIGH:
                    begin
                        bit_next   = bit_next + 4'd1;
                        phase_next = (bit_next >= 4'd8) ? P_MA_LOW : P_RX_LOW;
                    end
                    P_MA_LOW: phase_next = P_MA_HIGH;
                    P_MA_HIGH:
                    begin
                        byte_next = byte_next + CNT_W'(1);
                        if (byte_next < len_next)
                        begin
                            shift_next = '0;
                            bit_next   = '0;
                            phase_next = P_RX_LOW;
                        end
                        else
                        begin
                            phase_next = P_STOP_A;
                        end
                    end
                    P_STOP_A: phase_next = P_STOP_B;
                    P_STOP_B: phase_next = P_STOP_C;
                    default:
                    begin
                        res.done_res  = 1'b1;
                        res.ack_error = abort_next;
                        abort_next    = 1'b0;
                        phase_next    = P_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && mem_we)
        begin
            wbuf_mem[mem_waddr] <= item.write_byte;
        end
        mem_rd_reg <= wbuf_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= P_IDLE;
            stage_reg     <= ST_DEV;
            tick_reg      <= '0;
            bit_reg       <= '0;
            byte_reg      <= '0;
            shift_reg     <= '0;
            poll_reg      <= '0;
            fill_reg      <= '0;
            dev_reg       <= '0;
            regaddr_reg   <= '0;
            len_reg       <= '0;
            read_mode_reg <= 1'b0;
            abort_reg     <= 1'b0;
        end
        else if (step)
        begin
            phase_reg     <= phase_next;
            stage_reg     <= stage_next;
            tick_reg      <= tick_next;
            bit_reg       <= bit_next;
            byte_reg      <= byte_next;
            shift_reg     <= shift_next;
            poll_reg      <= poll_next;
            fill_reg      <= fill_next;
            dev_reg       <= dev_next;
            regaddr_reg   <= regaddr_next;
            len_reg       <= len_next;
            read_mode_reg <= read_mode_next;
            abort_reg     <= abort_next;
        end
    end

endmodule

`default_nettype wire

[rtl/i2c_register_burst_master_top.sv]
// Top level of the I2C register burst master: handshakes, configuration, result buffer.
// Instantiates i2crbm_core; uses i2crbm_pkg and i2c_register_burst_master_top_macros.svh.
`default_nettype none

// Bit-banged I2C master for register bursts. Each request is one timing tick and
// yields one result that carries the SCL and SDA levels for that tick, any received
// byte and the busy, done and error flags. One request is taken every clock cycle
// while the skid slot is empty. A two-entry result buffer, an output slot and a
// skid slot, lets one more request be taken while the result side stalls. Write
// configuration only while idle. Push the write bytes before a write burst begins.
`include "i2c_register_burst_master_top_macros.svh"

module i2c_register_burst_master_top #(
    parameter int BURST_DEPTH = 16
) (
    input  wire                                   logic clk,
    input  wire                                   logic rst_n,
    input  wire                                   logic in_valid,
    output logic                                  in_ready,
    input  i2crbm_pkg::in_t                       in_data,
    output logic                                  out_valid,
    input  wire                                   logic out_ready,
    output i2crbm_pkg::out_t                      out_data,
    input  wire                                   logic cfg_we,
    input  wire logic [i2crbm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [i2crbm_pkg::CFG_DATA_W-1:0] cfg_data
);

    i2crbm_pkg::cfg_t cfg_reg;
    i2crbm_pkg::out_t res;
    i2crbm_pkg::out_t out_reg;
    i2crbm_pkg::out_t skid_reg;
    logic             out_valid_reg;
    logic             skid_valid_reg;
    logic             step;
    logic             out_free;

    assign in_ready  = !skid_valid_reg;
    assign step      = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    i2crbm_core #(
        .BURST_DEPTH(BURST_DEPTH)
    ) u_core (
        .clk  (clk),
        .rst_n(rst_n),
        .step (step),
        .item (in_data),
        .cfg  (cfg_reg),
        .res  (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.setup_ticks    <= i2crbm_pkg::SETUP_TICKS_RST;
            cfg_reg.high_ticks     <= i2crbm_pkg::HIGH_TICKS_RST;
            cfg_reg.hold_ticks     <= i2crbm_pkg::HOLD_TICKS_RST;
            cfg_reg.ack_poll_limit <= i2crbm_pkg::ACK_POLL_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                i2crbm_pkg::CFG_SETUP_TICKS:    cfg_reg.setup_ticks    <= cfg_data;
                i2crbm_pkg::CFG_HIGH_TICKS:     cfg_reg.high_ticks     <= cfg_data;
                i2crbm_pkg::CFG_HOLD_TICKS:     cfg_reg.hold_ticks     <= cfg_data;
                i2crbm_pkg::CFG_ACK_POLL_LIMIT: cfg_reg.ack_poll_limit <= cfg_data[7:0];
                default:                        cfg_reg <= cfg_reg;
            endcase
        end
    end

    // hold stalled results in order: output slot first, then skid slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= step;
            end
        end
        else if (step)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
            end
            else if (step)
            begin
                out_reg <= res;
            end
        end
        else if (step)
        begin
            skid_reg <= res;
        end
    end

    `I2CRBM_ASSERT_IMP(a_skid_behind_out, skid_valid_reg, out_valid_reg, "skid full with empty output slot")
    `I2CRBM_ASSERT_NXT(a_stall_to_skid, step && !out_free, skid_valid_reg, "stalled request result lost")
    `I2CRBM_ASSERT_IMP(a_err_with_done, out_valid_reg && out_reg.ack_error, out_reg.done_res, "ack error without done")
    `I2CRBM_ASSERT_IMP(a_last_with_valid, out_valid_reg && out_reg.read_last, out_reg.read_valid, "read last without read valid")

endmodule

`default_nettype wire
